/* hw/rtl/tto_pkg.sv */
// Shared types, widths and codes for the theta-tree overload checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tto_pkg;

    localparam int TTO_NUM_LEAVES = 64;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CAP_W    = 16;
    localparam int TIME_W   = 20;
    localparam int DUR_W    = 16;
    localparam int LEAF_W   = 6;
    localparam int ENV_W    = 40;
    localparam int ENERGY_W = 39;
    localparam int STATUS_W = 3;
    localparam int NUM_W    = ENV_W + 1;
    localparam int DIV_STEPS = NUM_W;

    localparam logic [ENV_W-1:0]    ENV_MAX    = '1;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SKIPPED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RAISE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RAISED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CONFLICT = 3'd4;

    // Configuration register indexes
    localparam logic CFG_CAPACITY_MAX       = 1'b0;
    localparam logic CFG_CAPACITY_MIN_START = 1'b1;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_SKIP,
        K_INSERT
    } kind_t;

    // Classified command handed from front to back
    typedef struct packed {
        kind_t               kind;
        logic [LEAF_W-1:0]   leaf;
        logic [TIME_W-1:0]   end_max;
        logic [ENERGY_W-1:0] energy;
        logic [ENV_W-1:0]    envelope;
    } cmd_t;

    // One tree node; valid clear means envelope is minus infinity
    typedef struct packed {
        logic                valid;
        logic [ENV_W-1:0]    env;
        logic [ENERGY_W-1:0] energy;
    } node_t;

    // Leaf count rounded up to a power of two
    function automatic int tree_leaves(int n);
        int f;
        f = 1;
        while (f < n) f = f << 1;
        return f;
    endfunction

endpackage

/* hw/rtl/tto_front.sv */
// Front end: accepts input transactions, forms energy and envelope, classifies.
// Depends on tto_pkg.
`timescale 1ns / 1ps

module tto_front
    import tto_pkg::*;
#(
    parameter int NUM_LEAVES = TTO_NUM_LEAVES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hold,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [LEAF_W-1:0] leaf_index,
    input  logic [TIME_W-1:0] earliest_start,
    input  logic [TIME_W-1:0] end_max,
    input  logic [DUR_W-1:0]  duration_min,
    input  logic [DUR_W-1:0]  demand_min,
    input  logic [CAP_W-1:0]  cap_upper,
    output logic              push_valid,
    input  logic              push_ready,
    output cmd_t              push_data
);

    logic                     s1_valid_reg;
    logic                     s1_cmd_reg;
    logic                     s1_skip_reg;
    logic [LEAF_W-1:0]        s1_leaf_reg;
    logic [TIME_W-1:0]        s1_end_reg;
    logic [2*DUR_W-1:0]       s1_energy_reg;
    logic [TIME_W+CAP_W-1:0]  s1_sprod_reg;

    logic [2*DUR_W-1:0]       energy_c;
    logic [TIME_W+CAP_W-1:0]  sprod_c;
    logic                     accept;

    assign in_ready = !hold && (!s1_valid_reg || push_ready);
    assign accept   = in_valid && in_ready;

    // The two products of the insert, registered
    assign energy_c = duration_min * demand_min;
    assign sprod_c  = earliest_start * cap_upper;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= command;
            s1_skip_reg   <= (energy_c == '0) || (32'(leaf_index) >= 32'(NUM_LEAVES));
            s1_leaf_reg   <= leaf_index;
            s1_end_reg    <= end_max;
            s1_energy_reg <= energy_c;
            s1_sprod_reg  <= sprod_c;
        end
    end

    // Classify and build the queued command; the sum stays below 2^37
    always_comb
    begin
        push_valid          = s1_valid_reg;
        push_data.kind      = !s1_cmd_reg ? K_CLEAR : (s1_skip_reg ? K_SKIP : K_INSERT);
        push_data.leaf      = s1_leaf_reg;
        push_data.end_max   = s1_end_reg;
        push_data.energy    = ENERGY_W'(s1_energy_reg);
        push_data.envelope  = ENV_W'(s1_sprod_reg) + ENV_W'(s1_energy_reg);
    end

endmodule

/* hw/rtl/tto_queue.sv */
// Short command queue between front and back ends.
// Depends on tto_pkg.
`timescale 1ns / 1ps

module tto_queue
    import tto_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/tto_div.sv */
// Restoring divider, one quotient bit per cycle, for the capacity ceiling.
// Depends on tto_pkg.
`timescale 1ns / 1ps

module tto_div
    import tto_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  numerator,
    input  logic [TIME_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [NUM_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [NUM_W-1:0]  quo_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [TIME_W:0]   trial;
    logic              fits;

    // Shift in the next numerator bit and try a subtract
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numerator;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? TIME_W'(trial - {1'b0, div_reg}) : TIME_W'(trial);
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/tto_back.sv */
// Back end: theta-tree node memory, path update, ceiling division,
// leftmost-leaf search and result register. Depends on tto_pkg, tto_div.
`timescale 1ns / 1ps

module tto_back
    import tto_pkg::*;
#(
    parameter int NUM_LEAVES = TTO_NUM_LEAVES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  cmd_t                head_data,
    output logic                pop,
    output logic                init_busy,
    input  logic [CAP_W-1:0]    cap_upper,
    input  logic [CAP_W-1:0]    capacity_min_start,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [ENV_W-1:0]    root_envelope,
    output logic [ENV_W-1:0]    required_capacity,
    output logic [LEAF_W-1:0]   leftmost_leaf
);

    localparam int FIRST = tree_leaves(NUM_LEAVES);
    localparam int LW    = $clog2(FIRST);
    localparam int NW    = LW + 1;
    localparam int NODES = 2 * FIRST;
    localparam int PW    = (LW > LEAF_W) ? LW : LEAF_W;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_LEAF,
        S_UP_RD,
        S_UP_CALC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DECIDE,
        S_DN_RD,
        S_DN_CMP,
        S_RESULT
    } state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [NW-1:0]       sweep_reg;
    logic [NW-1:0]       p_reg;
    logic [ENV_W-1:0]    root_reg;
    logic [ENV_W-1:0]    req_reg;
    logic [ENV_W-1:0]    bound_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [LEAF_W-1:0]   res_lm_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ENV_W-1:0]    out_root_reg;
    logic [ENV_W-1:0]    out_req_reg;
    logic [LEAF_W-1:0]   out_lm_reg;

    node_t               mem [NODES];
    node_t               rd_a_reg;
    node_t               rd_b_reg;

    logic [PW-1:0]       leaf_wide;
    logic [NW-1:0]       leaf_addr;
    logic [NW-1:0]       addr_a;
    logic [NW-1:0]       addr_b;
    logic                wr_en;
    logic [NW-1:0]       wr_addr;
    node_t               wr_data;

    logic [ENV_W:0]      env_sum;
    logic [ENV_W-1:0]    env_a;
    logic [ENERGY_W:0]   energy_sum;
    node_t               upd;
    logic                same;
    logic [NW-1:0]       p_next;
    logic [PW-1:0]       lm_wide;

    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [NUM_W-1:0]    div_quo;
    logic [NUM_W-1:0]    numerator;
    logic                out_load;

    assign leaf_wide = PW'(cmd_reg.leaf);
    assign leaf_addr = {1'b1, leaf_wide[LW-1:0]};

    // Read ports: both children on the way up, node and right child on the way down
    assign addr_a = (state_reg == S_DN_RD) ? p_reg : {p_reg[NW-2:0], 1'b0};
    assign addr_b = {p_reg[NW-2:0], 1'b1};

    // Parent recompute from the two registered children
    always_comb
    begin
        env_sum    = {1'b0, rd_a_reg.env} + (ENV_W + 1)'(rd_b_reg.energy);
        env_a      = rd_a_reg.valid ? (env_sum[ENV_W] ? ENV_MAX : env_sum[ENV_W-1:0]) : '0;
        energy_sum = {1'b0, rd_a_reg.energy} + {1'b0, rd_b_reg.energy};
        upd.energy = energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];
        if (rd_a_reg.valid && (!rd_b_reg.valid || env_a >= rd_b_reg.env))
        begin
            upd.valid = 1'b1;
            upd.env   = env_a;
        end
        else
        begin
            upd.valid = rd_b_reg.valid;
            upd.env   = rd_b_reg.env;
        end
    end

    // Descent step toward the leftmost leaf that sets the envelope
    assign same    = (rd_a_reg.valid == rd_b_reg.valid) &&
                     (!rd_a_reg.valid || rd_a_reg.env == rd_b_reg.env);
    assign p_next  = {p_reg[NW-2:0], same};
    assign lm_wide = PW'(p_next[LW-1:0]);

    // Single write port of the node memory
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_reg;
        wr_data = '0;
        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_LEAF:
            begin
                wr_en          = 1'b1;
                wr_addr        = leaf_addr;
                wr_data.valid  = 1'b1;
                wr_data.env    = cmd_reg.envelope;
                wr_data.energy = cmd_reg.energy;
            end
            S_UP_CALC:
            begin
                wr_en   = 1'b1;
                wr_addr = p_reg;
                wr_data = upd;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Ceiling division unit
    assign numerator = {1'b0, root_reg} + NUM_W'(cmd_reg.end_max) - NUM_W'(1);
    assign div_start = (state_reg == S_DIV_GO) && (cmd_reg.end_max != '0);

    tto_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (numerator),
        .divisor   (cmd_reg.end_max),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo)
    );

    assign pop       = (state_reg == S_IDLE) && head_valid;
    assign init_busy = (state_reg == S_INIT);
    assign out_load  = (state_reg == S_RESULT) && (!out_valid_reg || out_ready);

    // Sequencer with result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cmd_reg        <= '0;
            sweep_reg      <= '0;
            p_reg          <= '0;
            root_reg       <= '0;
            req_reg        <= '0;
            bound_reg      <= '0;
            res_status_reg <= ST_CLEARED;
            res_lm_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_CLEARED;
            out_root_reg   <= '0;
            out_req_reg    <= '0;
            out_lm_reg     <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        cmd_reg    <= head_data;
                        root_reg   <= '0;
                        req_reg    <= '0;
                        res_lm_reg <= '0;
                        unique case (head_data.kind)
                            K_CLEAR:
                            begin
                                sweep_reg <= '0;
                                state_reg <= S_CLEAR;
                            end
                            K_SKIP:
                            begin
                                res_status_reg <= ST_SKIPPED;
                                state_reg      <= S_RESULT;
                            end
                            default:
                            begin
                                state_reg <= S_LEAF;
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == '1)
                    begin
                        bound_reg      <= ENV_W'(capacity_min_start);
                        res_status_reg <= ST_CLEARED;
                        state_reg      <= S_RESULT;
                    end
                end
                S_LEAF:
                begin
                    p_reg     <= leaf_addr >> 1;
                    state_reg <= S_UP_RD;
                end
                S_UP_RD:
                begin
                    state_reg <= S_UP_CALC;
                end
                S_UP_CALC:
                begin
                    if (p_reg == NW'(1))
                    begin
                        root_reg  <= upd.env;
                        state_reg <= S_DIV_GO;
                    end
                    else
                    begin
                        p_reg     <= p_reg >> 1;
                        state_reg <= S_UP_RD;
                    end
                end
                S_DIV_GO:
                begin
                    if (cmd_reg.end_max == '0)
                    begin
                        req_reg   <= ENV_MAX;
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        state_reg <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        req_reg   <= div_quo[ENV_W-1:0];
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (req_reg <= bound_reg)
                    begin
                        res_status_reg <= ST_NO_RAISE;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        p_reg     <= NW'(1);
                        state_reg <= S_DN_RD;
                    end
                end
                S_DN_RD:
                begin
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (p_next[NW-1])
                    begin
                        res_lm_reg <= lm_wide[LEAF_W-1:0];
                        if (req_reg > ENV_W'(cap_upper))
                        begin
                            res_status_reg <= ST_CONFLICT;
                        end
                        else
                        begin
                            res_status_reg <= ST_RAISED;
                            bound_reg      <= req_reg;
                        end
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        p_reg     <= p_next;
                        state_reg <= S_DN_RD;
                    end
                end
                S_RESULT:
                begin
                    if (out_load)
                    begin
                        out_status_reg <= res_status_reg;
                        out_root_reg   <= root_reg;
                        out_req_reg    <= req_reg;
                        out_lm_reg     <= res_lm_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign root_envelope     = out_root_reg;
    assign required_capacity = out_req_reg;
    assign leftmost_leaf     = out_lm_reg;

    // Checks
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_valid_reg && !out_ready) |=> (state_reg == S_RESULT))
        else $error("result slot overwritten");

    a_path_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_CALC) |-> upd.valid)
        else $error("node on insert path lost its envelope");

    a_raise: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DN_CMP && p_next[NW-1] && req_reg <= ENV_W'(cap_upper))
        |=> (bound_reg == $past(req_reg)))
        else $error("bound not raised");

    a_init_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> !pop)
        else $error("command taken during init sweep");

endmodule

/* hw/rtl/theta_tree_overload_check.sv */
// Top level of the theta-tree overload checker: config registers, front end,
// command queue and back end. Depends on tto_pkg, tto_front, tto_queue, tto_back.
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    command, leaf_index, earliest_start, end_max,
//                                              duration_min, demand_min
//  out       output     out_valid / out_ready  status, root_envelope, required_capacity,
//                                              leftmost_leaf
//  cfg       input      cfg_we                 cfg_index, cfg_data
//
//  An insert walks up the tree from its leaf to the root, runs the bit-serial divider
//  unless end_max is zero, and walks down only when the requirement exceeds the bound.
//  A skipped insert bypasses the tree; a clear sweeps the whole node memory.
//  After reset the same sweep runs and no input transaction is taken.
//  A two-entry queue and the output register let the front accept while results wait.

module theta_tree_overload_check
    import tto_pkg::*;
#(
    parameter int NUM_LEAVES = TTO_NUM_LEAVES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CAP_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [LEAF_W-1:0]   leaf_index,
    input  logic [TIME_W-1:0]   earliest_start,
    input  logic [TIME_W-1:0]   end_max,
    input  logic [DUR_W-1:0]    duration_min,
    input  logic [DUR_W-1:0]    demand_min,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [ENV_W-1:0]    root_envelope,
    output logic [ENV_W-1:0]    required_capacity,
    output logic [LEAF_W-1:0]   leftmost_leaf
);

    logic [CAP_W-1:0] cap_upper_reg;
    logic [CAP_W-1:0] capacity_min_start_reg;

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic head_valid;
    cmd_t head_data;
    logic pop;
    logic init_busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_upper_reg          <= '0;
            capacity_min_start_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAPACITY_MAX:       cap_upper_reg          <= cfg_data;
                CFG_CAPACITY_MIN_START: capacity_min_start_reg <= cfg_data;
                default:                cap_upper_reg          <= cap_upper_reg;
            endcase
        end
    end

    tto_front #(
        .NUM_LEAVES (NUM_LEAVES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .hold           (init_busy),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .leaf_index     (leaf_index),
        .earliest_start (earliest_start),
        .end_max        (end_max),
        .duration_min   (duration_min),
        .demand_min     (demand_min),
        .cap_upper      (cap_upper_reg),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    tto_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    tto_back #(
        .NUM_LEAVES (NUM_LEAVES)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head_valid         (head_valid),
        .head_data          (head_data),
        .pop                (pop),
        .init_busy          (init_busy),
        .cap_upper          (cap_upper_reg),
        .capacity_min_start (capacity_min_start_reg),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .root_envelope      (root_envelope),
        .required_capacity  (required_capacity),
        .leftmost_leaf      (leftmost_leaf)
    );

endmodule

/* test/tto_checker.sv */
// Checker for the theta-tree overload checker: watches the cfg, in and out channels,
// predicts each result from its own tree copy and compares it. Depends on tto_pkg.
`timescale 1ns / 1ps

module tto_checker
    import tto_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CAP_W-1:0]    cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                command,
    input  logic [LEAF_W-1:0]   leaf_index,
    input  logic [TIME_W-1:0]   earliest_start,
    input  logic [TIME_W-1:0]   end_max,
    input  logic [DUR_W-1:0]    duration_min,
    input  logic [DUR_W-1:0]    demand_min,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [ENV_W-1:0]    root_envelope,
    input  logic [ENV_W-1:0]    required_capacity,
    input  logic [LEAF_W-1:0]   leftmost_leaf,
    output int                  fail_count,
    output int                  pending_count,
    output int                  result_count,
    output int                  raised_count,
    output int                  conflict_count
);

    localparam int LEAVES = tree_leaves(TTO_NUM_LEAVES);
    localparam int NODES  = 2 * LEAVES;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENV_W-1:0]    root;
        logic [ENV_W-1:0]    req;
        logic [LEAF_W-1:0]   leaf;
    } outcome_t;

    // Shadow tree and bound
    logic [ENERGY_W-1:0] tree_energy [NODES];
    logic [ENV_W-1:0]    tree_env    [NODES];
    logic                tree_vld    [NODES];
    logic [ENV_W-1:0]    bound;
    logic [CAP_W-1:0]    cap_max;
    logic [CAP_W-1:0]    cap_min0;

    outcome_t expected_q[$];

    function automatic longint unsigned clamp(longint unsigned v, longint unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic void wipe_tree();
        for (int i = 0; i < NODES; i++)
        begin
            tree_energy[i] = '0;
            tree_env[i]    = '0;
            tree_vld[i]    = 1'b0;
        end
    endfunction

    // Recompute one internal node from its children
    function automatic void merge_node(int p);
        int l;
        int r;
        longint unsigned a;
        l = 2 * p;
        r = l + 1;
        a = tree_vld[l] ? clamp(longint'(tree_env[l]) + longint'(tree_energy[r]), ENV_MAX) : 0;
        tree_energy[p] = ENERGY_W'(clamp(longint'(tree_energy[l]) + longint'(tree_energy[r]),
                                         ENERGY_MAX));
        if (tree_vld[l] && (!tree_vld[r] || a >= longint'(tree_env[r])))
        begin
            tree_env[p] = ENV_W'(a);
            tree_vld[p] = 1'b1;
        end
        else
        begin
            tree_env[p] = tree_env[r];
            tree_vld[p] = tree_vld[r];
        end
    endfunction

    // Walk down taking the right child whenever it carries the same envelope
    function automatic logic [LEAF_W-1:0] find_leftmost();
        int p;
        int r;
        logic same;
        p = 1;
        while (p < LEAVES)
        begin
            r = 2 * p + 1;
            same = (tree_vld[p] == tree_vld[r]) && (!tree_vld[p] || tree_env[p] == tree_env[r]);
            p = same ? r : r - 1;
        end
        return LEAF_W'(p - LEAVES);
    endfunction

    function automatic outcome_t predict_outcome(logic cmd, logic [LEAF_W-1:0] leaf,
        logic [TIME_W-1:0] st, logic [TIME_W-1:0] em, logic [DUR_W-1:0] dur,
        logic [DUR_W-1:0] dem);
        outcome_t o;
        longint unsigned nrg;
        longint unsigned root;
        longint unsigned req;
        int node;
        o = '0;
        if (cmd == 1'b0)
        begin
            wipe_tree();
            bound = ENV_W'(cap_min0);
            o.status = ST_CLEARED;
            return o;
        end
        nrg = longint'(dur) * longint'(dem);
        if (nrg == 0 || int'(leaf) >= TTO_NUM_LEAVES)
        begin
            o.status = ST_SKIPPED;
            return o;
        end
        node = LEAVES + int'(leaf);
        tree_energy[node] = ENERGY_W'(nrg);
        tree_env[node]    = ENV_W'(clamp(longint'(st) * longint'(cap_max) + nrg, ENV_MAX));
        tree_vld[node]    = 1'b1;
        for (int n = node >> 1; n != 0; n = n >> 1)
            merge_node(n);
        root = longint'(tree_env[1]);
        req  = (em == 0) ? longint'(ENV_MAX) : (root + longint'(em) - 1) / longint'(em);
        o.root = ENV_W'(root);
        o.req  = ENV_W'(req);
        if (req <= longint'(bound))
            o.status = ST_NO_RAISE;
        else
        begin
            o.leaf = find_leftmost();
            if (req > longint'(cap_max))
                o.status = ST_CONFLICT;
            else
            begin
                o.status = ST_RAISED;
                bound = ENV_W'(req);
            end
        end
        return o;
    endfunction

    // Results first (they belong to older transactions), then new inputs, then cfg
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e;
        if (!rst_n)
        begin
            wipe_tree();
            bound          = '0;
            cap_max        = '0;
            cap_min0       = '0;
            fail_count     = 0;
            result_count   = 0;
            raised_count   = 0;
            conflict_count = 0;
            expected_q.delete();
            pending_count  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_q.size() == 0)
                begin
                    $error("result with no pending transaction: status %0d", status);
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.status == ST_RAISED)   raised_count++;
                    if (e.status == ST_CONFLICT) conflict_count++;
                    if (status !== e.status)
                    begin
                        $error("status: expected %0d, actual %0d", e.status, status);
                        fail_count++;
                    end
                    if (root_envelope !== e.root)
                    begin
                        $error("root_envelope: expected %0d, actual %0d", e.root, root_envelope);
                        fail_count++;
                    end
                    if (required_capacity !== e.req)
                    begin
                        $error("required_capacity: expected %0d, actual %0d",
                               e.req, required_capacity);
                        fail_count++;
                    end
                    if (leftmost_leaf !== e.leaf)
                    begin
                        $error("leftmost_leaf: expected %0d, actual %0d", e.leaf, leftmost_leaf);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.insert(expected_q.size(),
                                  predict_outcome(command, leaf_index, earliest_start, end_max,
                                                  duration_min, demand_min));
            if (cfg_we)
            begin
                if (cfg_index == CFG_CAPACITY_MAX)
                    cap_max = cfg_data;
                else
                    cap_min0 = cfg_data;
            end
            pending_count = expected_q.size();
        end
    end

endmodule

/* test/tb_theta_tree_overload_check.sv */
// Testbench top for theta_tree_overload_check: clock, reset, stimulus and verdict.
// Depends on tto_pkg, the block and tto_checker.
`timescale 1ns / 1ps

module tb_theta_tree_overload_check;
    import tto_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 250;
    localparam int HOLD_CYCLES    = 400;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [CAP_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic                command;
    logic [LEAF_W-1:0]   leaf_index;
    logic [TIME_W-1:0]   earliest_start;
    logic [TIME_W-1:0]   end_max;
    logic [DUR_W-1:0]    duration_min;
    logic [DUR_W-1:0]    demand_min;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [ENV_W-1:0]    root_envelope;
    logic [ENV_W-1:0]    required_capacity;
    logic [LEAF_W-1:0]   leftmost_leaf;

    int  fail_count;
    int  pending_count;
    int  result_count;
    int  raised_count;
    int  conflict_count;
    int  idle_cycles = 0;
    int  sent_count;
    bit  quiet;
    bit  hold_request;
    bit  hold_done = 1'b0;

    theta_tree_overload_check dut (.*);

    tto_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_theta_tree_overload_check NOT OK");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                out_ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Offer one transaction and hold it until accepted
    task automatic send_item(logic cmd, logic [LEAF_W-1:0] leaf, logic [TIME_W-1:0] st,
                             logic [TIME_W-1:0] em, logic [DUR_W-1:0] dur,
                             logic [DUR_W-1:0] dem);
        bit taken;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        leaf_index     <= leaf;
        earliest_start <= st;
        end_max        <= em;
        duration_min   <= dur;
        demand_min     <= dem;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        sent_count++;
    endtask

    // Drain all results, then let the block finish any background work
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic idx, logic [CAP_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_noise();
        send_item($urandom_range(0, 7) != 0, LEAF_W'($urandom), TIME_W'($urandom),
                  ($urandom_range(0, 9) == 0) ? '0 : TIME_W'($urandom),
                  ($urandom_range(0, 9) == 0) ? '0 : DUR_W'($urandom),
                  ($urandom_range(0, 9) == 0) ? '0 : DUR_W'($urandom));
    endtask

    // A clear followed by tasks placed at leaves in earliest-start order
    task automatic run_schedule(int n, int cap);
        int t;
        int stride;
        int leaf;
        int st;
        t      = $urandom_range(0, 50);
        stride = (n > 32) ? 1 : $urandom_range(1, 64 / n);
        send_item(1'b0, '0, '0, 20'd1, '0, '0);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_noise();
                continue;
            end
            leaf = (k * stride) % 64;
            if (k > 0 && $urandom_range(0, 11) == 0)
                leaf = ((k - 1) * stride) % 64;
            st = t;
            t  = t + $urandom_range(0, 12);
            send_item(1'b1, LEAF_W'(leaf), TIME_W'(st),
                      TIME_W'(st + $urandom_range(1, 120)),
                      DUR_W'($urandom_range(1, 30)),
                      DUR_W'($urandom_range(1, (cap < 2) ? 3 : cap)));
        end
    endtask

    initial
    begin
        int caps[6];
        int mins[6];
        int n;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_CAPACITY_MAX;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = 1'b0;
        leaf_index     = '0;
        earliest_start = '0;
        end_max        = '0;
        duration_min   = '0;
        demand_min     = '0;
        quiet          = 1'b0;
        hold_request   = 1'b0;
        sent_count     = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: skips, extremes, repeated leaf, zero divisor, raise and conflict
        cfg_write(CFG_CAPACITY_MAX, 16'd100);
        cfg_write(CFG_CAPACITY_MIN_START, 16'd0);
        send_item(1'b0, '0, '0, 20'd1, '0, '0);
        send_item(1'b1, 6'd0, 20'd5, 20'd10, 16'd0, 16'd7);
        send_item(1'b1, 6'd0, 20'd5, 20'd10, 16'd7, 16'd0);
        send_item(1'b1, 6'd3, 20'd0, 20'd10, 16'd5, 16'd20);
        send_item(1'b1, 6'd4, 20'd2, 20'd20, 16'd1, 16'd1);
        send_item(1'b1, 6'd5, 20'd3, 20'd12, 16'd10, 16'd90);
        send_item(1'b1, 6'd5, 20'd3, 20'd12, 16'd1, 16'd1);
        send_item(1'b1, 6'd6, 20'd4, 20'd0, 16'd2, 16'd2);
        send_item(1'b1, 6'd63, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 6'd0, 20'd0, 20'd1, 16'hFFFF, 16'hFFFF);
        settle();
        cfg_write(CFG_CAPACITY_MAX, 16'hFFFF);
        cfg_write(CFG_CAPACITY_MIN_START, 16'hFFFF);
        send_item(1'b0, 6'h3F, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 6'd0, 20'hFFFFF, 20'd1, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 6'd63, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 6'd1, 20'd0, 20'hFFFFF, 16'd1, 16'd1);
        send_item(1'b1, 6'd2, 20'd0, 20'd0, 16'd1, 16'd1);
        settle();

        // Random phases over a spread of capacity settings
        caps = '{0, 65535, 20, 5, 200, 1};
        mins = '{0, 65535, 3, 0, 100, 1};
        for (int ph = 0; ph < 6; ph++)
        begin
            cfg_write(CFG_CAPACITY_MAX,
                      (ph == 4) ? CAP_W'($urandom) | CAP_W'(caps[ph]) : CAP_W'(caps[ph]));
            cfg_write(CFG_CAPACITY_MIN_START,
                      (ph == 5) ? CAP_W'($urandom) : CAP_W'(mins[ph]));
            if (ph == 5)
                quiet = 1'b1;
            n = 0;
            while (n < 100)
            begin
                if (ph == 2 && n == 40)
                    hold_request = 1'b1;
                run_schedule((n % 3 == 0) ? 64 : $urandom_range(3, 24), caps[ph]);
                n = n + 20;
            end
            repeat (10) send_noise();
            settle();
        end

        $display("Covered %0d input transactions and %0d results (%0d raised, %0d conflict)",
                 sent_count, result_count, raised_count, conflict_count);
        $display("over six capacity settings, stall bursts and one long output hold-off.");
        if (fail_count == 0 && pending_count == 0)
            $display("tb_theta_tree_overload_check OK");
        else
            $display("tb_theta_tree_overload_check NOT OK");
        $finish;
    end

endmodule
